>>> rtl/bpra_pkg.sv
package bpra_pkg;

    // Bitmap storage word
    localparam int WORD_W  = 32;
    localparam int WORD_LG = 5;

    // Default sizing
    localparam int DEF_MAX_PAGES = 1024;
    localparam int DEF_MAX_RUN   = 16;

    // Field widths
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 5;
    localparam int PAGES_W    = 11;
    localparam int SHIFT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Page shift limits
    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd16;
    localparam int OFF_W = ADDR_W - 8;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 2'd2;

    // Register reset values
    localparam logic [ADDR_W-1:0]  RST_REGION_BASE  = 32'h0010_0000;
    localparam logic [PAGES_W-1:0] RST_PAGES_IN_USE = 11'd1024;
    localparam logic [SHIFT_W-1:0] RST_PAGE_SHIFT   = 5'd12;

    typedef struct packed {
        logic              op;
        logic [LEN_W-1:0]  run_length;
        logic [ADDR_W-1:0] free_address;
    } t_alloc_req;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic [STATUS_W-1:0] status;
    } t_alloc_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FCHECK,
        S_SCAN_PRIME,
        S_SCAN,
        S_MARK_RD,
        S_MARK_WR,
        S_ADDR,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                clr_wr;
        logic                load;
        logic                calc_off;
        logic                scan_init;
        logic                scan_step;
        logic                take_hit;
        logic                mark_init;
        logic                mark_rd;
        logic                mark_wr;
        logic                addr_calc;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic len_bad;
        logic below_base;
        logic range_bad;
        logic hit;
        logic scan_last;
        logic mark_last;
        logic out_busy;
    } t_dp_sts;

endpackage

>>> rtl/bpra_datapath.sv
module bpra_datapath #(
    parameter int MAX_PAGES = bpra_pkg::DEF_MAX_PAGES,
    parameter int MAX_RUN   = bpra_pkg::DEF_MAX_RUN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpra_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  bpra_pkg::t_alloc_req                i_in_item,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output bpra_pkg::t_alloc_rsp                o_out_item,
    input  bpra_pkg::t_dp_cmd                   i_cmd,
    output bpra_pkg::t_dp_sts                   o_sts
);
    import bpra_pkg::*;

    localparam int WORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PG_W  = WA_W + WORD_LG + 1;
    localparam int CR_W  = $clog2(MAX_RUN + 1);
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);
    localparam logic [PG_W-1:0] MAX_PG    = PG_W'(MAX_PAGES);

    function automatic logic [WORD_W-1:0] lowmask(input logic [WORD_LG:0] n);
        logic [WORD_W-1:0] m;
        if (n >= (WORD_LG + 1)'(WORD_W)) begin
            m = '1;
        end else begin
            m = (WORD_W'(1) << n) - WORD_W'(1);
        end
        return m;
    endfunction

    // Configuration
    logic [ADDR_W-1:0]  r_base;
    logic [PAGES_W-1:0] r_pages;
    logic [SHIFT_W-1:0] r_shift;

    // Current item
    logic               r_op;
    logic [LEN_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_addr;
    logic [OFF_W-1:0]   r_off;

    // Bitmap
    logic [WORD_W-1:0]  r_mem [WORDS];
    logic [WORD_W-1:0]  r_q;
    logic [WA_W-1:0]    r_clr;
    logic [WA_W-1:0]    rd_addr;

    // Scan
    logic [WA_W-1:0]    r_word;
    logic [CR_W-1:0]    r_carry;
    logic [CR_W-1:0]    n_carry;
    logic [WORD_W-1:0]  used;
    logic               hit;
    logic [WORD_LG-1:0] hit_j;
    logic [PG_W-1:0]    hit_start;

    // Mark
    logic [PG_W-1:0]    r_idx;
    logic [PG_W-1:0]    mk_src;
    logic [WA_W-1:0]    r_mk_word;
    logic [WORD_LG-1:0] r_mk_lo;
    logic [LEN_W-1:0]   r_mk_left;
    logic [WORD_LG:0]   mk_room;
    logic [WORD_LG:0]   mk_cnt;
    logic [WORD_W-1:0]  mk_mask;
    logic [WORD_W-1:0]  mk_data;

    // Result
    logic [ADDR_W-1:0]   r_res_addr;
    logic [STATUS_W-1:0] r_status;
    logic                r_out_valid;
    t_alloc_rsp          r_out_item;

    logic [SHIFT_W-1:0] shift_eff;
    logic [PG_W-1:0]    total;
    logic [PG_W-1:0]    total_m1;
    logic [WA_W-1:0]    last_w;
    logic [ADDR_W-1:0]  diff;

    always_comb begin
        if (r_shift < SHIFT_MIN) begin
            shift_eff = SHIFT_MIN;
        end else if (r_shift > SHIFT_MAX) begin
            shift_eff = SHIFT_MAX;
        end else begin
            shift_eff = r_shift;
        end
        if (32'(r_pages) > 32'(MAX_PAGES)) begin
            total = MAX_PG;
        end else begin
            total = PG_W'(r_pages);
        end
        total_m1 = total - PG_W'(1);
        last_w   = (total == '0) ? '0 : total_m1[WA_W+WORD_LG-1:WORD_LG];
        diff     = r_addr - r_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_REGION_BASE;
            r_pages <= RST_PAGES_IN_USE;
            r_shift <= RST_PAGE_SHIFT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REGION_BASE:  r_base  <= i_cfg_data;
                CFG_PAGES_IN_USE: r_pages <= i_cfg_data[PAGES_W-1:0];
                CFG_PAGE_SHIFT:   r_shift <= i_cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Window test: a run of r_len free pages ends at bit j when the bits inside
    // this word are free and the free tail carried in covers the rest.
    always_comb begin
        int nwin;
        int lo;
        int tf;
        int csum;
        logic [WORD_W-1:0] m;
        used = r_q;
        for (int b = 0; b < WORD_W; b++) begin
            if (PG_W'({r_word, WORD_LG'(b)}) >= total) begin
                used[b] = 1'b1;
            end
        end
        hit   = 1'b0;
        hit_j = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            nwin = j + 1;
            lo   = (nwin > int'(r_len)) ? nwin - int'(r_len) : 0;
            m    = lowmask((WORD_LG + 1)'(nwin)) & ~lowmask((WORD_LG + 1)'(lo));
            if (((used & m) == '0) && (int'(r_carry) + nwin >= int'(r_len))) begin
                hit   = 1'b1;
                hit_j = WORD_LG'(j);
            end
        end
        hit_start = PG_W'({r_word, hit_j}) + PG_W'(1) - PG_W'(r_len);
        tf = WORD_W;
        for (int b = 0; b < WORD_W; b++) begin
            if (used[b]) begin
                tf = WORD_W - 1 - b;
            end
        end
        csum    = (used == '0) ? int'(r_carry) + WORD_W : tf;
        n_carry = (csum > MAX_RUN) ? CR_W'(MAX_RUN) : CR_W'(csum);
    end

    always_comb begin
        mk_room = (WORD_LG + 1)'(WORD_W) - {1'b0, r_mk_lo};
        mk_cnt  = ({1'b0, r_mk_left} < mk_room) ? {1'b0, r_mk_left} : mk_room;
        mk_mask = lowmask(mk_cnt) << r_mk_lo;
        mk_data = (r_op == OP_ALLOC) ? (r_q | mk_mask) : (r_q & ~mk_mask);
        mk_src  = i_cmd.take_hit ? hit_start : PG_W'(r_off);
        if (i_cmd.mark_rd) begin
            rd_addr = r_mk_word;
        end else if (i_cmd.scan_init) begin
            rd_addr = '0;
        end else if (r_word == LAST_WORD) begin
            rd_addr = r_word;
        end else begin
            rd_addr = r_word + WA_W'(1);
        end
    end

    // Bitmap memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.mark_wr) begin
            r_mem[r_mk_word] <= mk_data;
        end
        r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr <= r_clr + WA_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in_item.op;
            r_len      <= i_in_item.run_length;
            r_addr     <= i_in_item.free_address;
            r_res_addr <= '0;
        end
        if (i_cmd.calc_off) begin
            r_off <= OFF_W'(diff >> shift_eff);
        end
        if (i_cmd.scan_init) begin
            r_word  <= '0;
            r_carry <= '0;
        end else if (i_cmd.scan_step) begin
            r_word  <= r_word + WA_W'(1);
            r_carry <= n_carry;
        end
        if (i_cmd.take_hit || i_cmd.mark_init) begin
            r_idx     <= mk_src;
            r_mk_word <= mk_src[WA_W+WORD_LG-1:WORD_LG];
            r_mk_lo   <= mk_src[WORD_LG-1:0];
            r_mk_left <= r_len;
        end else if (i_cmd.mark_wr) begin
            r_mk_word <= r_mk_word + WA_W'(1);
            r_mk_lo   <= '0;
            r_mk_left <= r_mk_left - LEN_W'(mk_cnt);
        end
        if (i_cmd.addr_calc) begin
            r_res_addr <= r_base + ADDR_W'(64'(r_idx) << shift_eff);
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_out_item.result_address <= r_res_addr;
            r_out_item.status         <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.clr_last   = (r_clr == LAST_WORD);
        o_sts.is_free    = (r_op == OP_FREE);
        o_sts.len_bad    = (r_len == '0) || (32'(r_len) > 32'(MAX_RUN));
        o_sts.below_base = (r_addr < r_base);
        o_sts.range_bad  = (32'(r_off) >= 32'(total))
                        || (32'(r_len) > (32'(total) - 32'(r_off)));
        o_sts.hit        = hit;
        o_sts.scan_last  = (r_word == last_w);
        o_sts.mark_last  = ({1'b0, r_mk_left} == mk_cnt);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/bpra_ctrl.sv
module bpra_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bpra_pkg::t_dp_sts   i_sts,
    output bpra_pkg::t_dp_cmd   o_cmd
);
    import bpra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.calc_off = 1'b1;
                if (!i_sts.is_free) begin
                    if (i_sts.len_bad) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NO_ROOM;
                        n_state          = S_RESP;
                    end else begin
                        n_state = S_SCAN_PRIME;
                    end
                end else if (i_sts.len_bad || i_sts.below_base) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OUT_OF_RANGE;
                    n_state          = S_RESP;
                end else begin
                    n_state = S_FCHECK;
                end
            end
            S_FCHECK: begin
                if (i_sts.range_bad) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OUT_OF_RANGE;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.mark_init = 1'b1;
                    n_state         = S_MARK_RD;
                end
            end
            S_SCAN_PRIME: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_MARK_RD;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_ROOM;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_MARK_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MARK_WR;
            end
            S_MARK_WR: begin
                o_cmd.mark_wr = 1'b1;
                if (!i_sts.mark_last) begin
                    n_state = S_MARK_RD;
                end else if (i_sts.is_free) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_RESP;
                end else begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr_calc  = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_OK;
                n_state          = S_RESP;
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bitmap_page_run_allocator_unit.sv
// Channel   Direction  Handshake                  Beat payload
// -------   ---------  -------------------------  ------------------------------------
// in        input      i_in_valid / o_in_ready    t_alloc_req: op, run_length, address
// out       output     o_out_valid / i_out_ready  t_alloc_rsp: result_address, status
// cfg       input      i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// After reset the bitmap is swept to all-free, one 32-bit word a cycle, with
// o_in_ready low meanwhile. Allocate: checks, then a scan of one bitmap word a
// cycle (up to ceil(pages_in_use/32) words), then a read state and a write
// state per word of the run marked, then the address step. Free: checks, a
// range check, then a read state and a write state per word touched. One beat
// in flight; a result held in the output register does not block the next
// input beat until that beat's result is ready.
module bitmap_page_run_allocator_unit #(
    parameter int MAX_PAGES = bpra_pkg::DEF_MAX_PAGES,
    parameter int MAX_RUN   = bpra_pkg::DEF_MAX_RUN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bpra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bpra_pkg::t_alloc_req            i_in_item,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bpra_pkg::t_alloc_rsp            o_out_item
);
    import bpra_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: clear pass, checks, word scan, read-modify-write marking
    bpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Configuration registers, bitmap memory, run search, address math and the output register
    bpra_datapath #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_RUN   (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // An accepted beat closes the input until its result is loaded
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out_valid && !i_out_ready))
        else $error("result register overwritten");

    // Failures carry a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status != ST_OK |-> o_out_item.result_address == '0)
        else $error("failed request with nonzero address");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.status == ST_OK || o_out_item.status == ST_NO_ROOM
                        || o_out_item.status == ST_OUT_OF_RANGE)
        else $error("undefined status code");

endmodule
